// File: hw/rtl/tbdc_pkg.sv
// Shared types and constants for the two-button debounce and duty control block.
`default_nettype none
package tbdc_pkg;

	localparam int DUTY_FULL_SCALE = 100;
	localparam int STEP_W  = 7;
	localparam int MAG_W   = 7;
	localparam int DUTY_W  = $clog2(DUTY_FULL_SCALE + 1) + 1;
	localparam int SUM_W   = ((DUTY_W > STEP_W) ? DUTY_W : STEP_W) + 2;
	localparam int CNT_W   = 16;
	localparam int STAB_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [STAB_W-1:0] STABLE_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_READS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_READS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMP_HOLD_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_TICKS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP       = 3'd4;

	localparam logic [STAB_W-1:0] RST_DEBOUNCE_READS  = 8'd10;
	localparam logic [CNT_W-1:0]  RST_REPEAT_READS    = 16'd6000;
	localparam logic [CNT_W-1:0]  RST_LAMP_HOLD_TICKS = 16'd1000;
	localparam logic [CNT_W-1:0]  RST_DISPLAY_TICKS   = 16'd2000;
	localparam logic [STEP_W-1:0] RST_DUTY_STEP       = 7'd1;

	typedef struct packed {
		logic raw_up_button;
		logic raw_down_button;
	} in_item_t;

	typedef struct packed {
		logic              up_level;
		logic              down_level;
		logic [MAG_W-1:0]  duty_magnitude;
		logic              reverse_dir;
		logic              drive_update;
		logic              up_ack_lamp;
		logic              down_ack_lamp;
		logic              at_plus_full;
		logic              at_minus_full;
		logic              display_strobe;
	} out_item_t;

	typedef struct packed {
		logic [STAB_W-1:0] debounce_reads;
		logic [CNT_W-1:0]  repeat_reads;
		logic [CNT_W-1:0]  lamp_hold_ticks;
		logic [CNT_W-1:0]  display_ticks;
		logic [STEP_W-1:0] duty_step;
	} cfg_t;

	// per-button status after this tick's debounce
	typedef struct packed {
		logic level;
		logic pend;
		logic dbl;
	} btn_stat_t;

	// duty command taken by the duty register
	typedef struct packed {
		logic negate;
		logic up_go;
		logic down_go;
	} duty_cmd_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             plus_full;
		logic             minus_full;
	} duty_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/tbdc_button.sv
// Debounce, auto-repeat and release-detect for one button.
`default_nettype none
module tbdc_button (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          raw,
	input  wire logic                          other_raw,
	input  wire logic                          clr_pend,
	input  wire logic [tbdc_pkg::STAB_W-1:0]   debounce_reads,
	input  wire logic [tbdc_pkg::CNT_W-1:0]    repeat_reads,
	output tbdc_pkg::btn_stat_t                stat
);

	logic                        deb_q, last_q, pend_q;
	logic [tbdc_pkg::STAB_W-1:0] stable_q, stable_trk, stable_n;
	logic [tbdc_pkg::CNT_W-1:0]  rep_q, rep_inc, rep_n;
	logic                        deb_n, pend_n, dbl;

	always_comb begin
		if (raw == last_q) begin
			stable_trk = (stable_q == tbdc_pkg::STABLE_MAX) ? stable_q : stable_q + 8'd1;
		end else begin
			stable_trk = '0;
		end
		rep_inc  = rep_q + 16'd1;
		deb_n    = deb_q;
		stable_n = stable_trk;
		rep_n    = rep_q;
		pend_n   = pend_q;
		dbl      = 1'b0;
		if (stable_trk == debounce_reads && deb_q != raw) begin
			dbl      = deb_q & other_raw;
			deb_n    = raw;
			stable_n = '0;
			rep_n    = '0;
			pend_n   = raw;
		end else if (deb_q == raw) begin
			if (rep_inc == repeat_reads) begin
				pend_n = pend_q | deb_q;
				rep_n  = '0;
			end else begin
				rep_n = rep_inc;
			end
		end
	end

	assign stat.level = deb_n;
	assign stat.pend  = pend_n;
	assign stat.dbl   = dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q    <= 1'b0;
			last_q   <= 1'b0;
			pend_q   <= 1'b0;
			stable_q <= '0;
			rep_q    <= '0;
		end else if (en) begin
			deb_q    <= deb_n;
			last_q   <= raw;
			pend_q   <= clr_pend ? 1'b0 : pend_n;
			stable_q <= stable_n;
			rep_q    <= rep_n;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tbdc_duty.sv
// Signed duty register with step, clamp and sign reversal.
`default_nettype none
module tbdc_duty (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire tbdc_pkg::duty_cmd_t           cmd,
	input  wire logic [tbdc_pkg::STEP_W-1:0]   step,
	output tbdc_pkg::duty_stat_t               stat
);

	localparam int DW = tbdc_pkg::DUTY_W;
	localparam int SW = tbdc_pkg::SUM_W;
	localparam logic signed [SW-1:0] FS_POS = SW'(tbdc_pkg::DUTY_FULL_SCALE);
	localparam logic signed [SW-1:0] FS_NEG = -FS_POS;
	localparam logic signed [DW-1:0] DUTY_RST = DW'(tbdc_pkg::DUTY_FULL_SCALE / 2);

	logic signed [DW-1:0] duty_q, duty_n, duty_abs;
	logic signed [SW-1:0] duty_x, step_x, sum_up, sum_dn;

	always_comb begin
		duty_x = SW'(duty_q);
		step_x = SW'({1'b0, step});
		sum_up = duty_x + step_x;
		sum_dn = duty_x - step_x;
		if (sum_up > FS_POS) begin
			sum_up = FS_POS;
		end
		if (sum_dn < FS_NEG) begin
			sum_dn = FS_NEG;
		end
		if (cmd.negate) begin
			duty_n = -duty_q;
		end else if (cmd.up_go) begin
			duty_n = sum_up[DW-1:0];
		end else if (cmd.down_go) begin
			duty_n = sum_dn[DW-1:0];
		end else begin
			duty_n = duty_q;
		end
		duty_abs = duty_n[DW-1] ? -duty_n : duty_n;
	end

	assign stat.mag        = tbdc_pkg::MAG_W'(duty_abs);
	assign stat.neg        = duty_n[DW-1];
	assign stat.plus_full  = SW'(duty_n) >= FS_POS;
	assign stat.minus_full = SW'(duty_n) <= FS_NEG;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= DUTY_RST;
		end else if (en) begin
			duty_q <= duty_n;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/two_button_debounce_duty_control.sv
// Top level: input stage, button trackers, duty register, lamps, strobe and result register.
// Path: the accepted transaction waits in the input stage and is loaded into the result
//   register on advance, when the result register is empty or being drained.
// Throughput: one transaction per cycle while the result side is free or being drained;
//   the input stage then feeds the state update and the result register on each advance.
// Reset (arst_n low, asynchronous): all counters and flags clear, duty goes to half
//   plus full scale, the display counter and registers take their default values.
`default_nettype none
module two_button_debounce_duty_control (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire tbdc_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output tbdc_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_we,
	input  wire logic [tbdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tbdc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	tbdc_pkg::cfg_t       cfg_q;
	tbdc_pkg::in_item_t   data_s1;
	logic                 valid_s1;
	tbdc_pkg::out_item_t  out_q;
	logic                 out_valid_q;
	logic                 advance;

	tbdc_pkg::btn_stat_t  up_stat, down_stat;
	tbdc_pkg::duty_cmd_t  cmd;
	tbdc_pkg::duty_stat_t duty_stat;
	logic                 dbl_any, up_clr, down_clr;

	logic [tbdc_pkg::CNT_W-1:0] up_lamp_q, down_lamp_q, up_lamp_n, down_lamp_n;
	logic [tbdc_pkg::CNT_W-1:0] disp_q, disp_dec, disp_n;
	logic                       strobe;

	// Move the stage on whenever the result register is empty or being drained.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration: take each write at once; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_reads  <= tbdc_pkg::RST_DEBOUNCE_READS;
			cfg_q.repeat_reads    <= tbdc_pkg::RST_REPEAT_READS;
			cfg_q.lamp_hold_ticks <= tbdc_pkg::RST_LAMP_HOLD_TICKS;
			cfg_q.display_ticks   <= tbdc_pkg::RST_DISPLAY_TICKS;
			cfg_q.duty_step       <= tbdc_pkg::RST_DUTY_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				tbdc_pkg::CFG_DEBOUNCE_READS: begin
					cfg_q.debounce_reads <= cfg_wdata[tbdc_pkg::STAB_W-1:0];
				end
				tbdc_pkg::CFG_REPEAT_READS: begin
					cfg_q.repeat_reads <= cfg_wdata[tbdc_pkg::CNT_W-1:0];
				end
				tbdc_pkg::CFG_LAMP_HOLD_TICKS: begin
					cfg_q.lamp_hold_ticks <= cfg_wdata[tbdc_pkg::CNT_W-1:0];
				end
				tbdc_pkg::CFG_DISPLAY_TICKS: begin
					cfg_q.display_ticks <= cfg_wdata[tbdc_pkg::CNT_W-1:0];
				end
				tbdc_pkg::CFG_DUTY_STEP: begin
					cfg_q.duty_step <= cfg_wdata[tbdc_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input stage: hold the accepted transaction until the state update takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// Button trackers. Each sees the other's raw level for release detection.
	tbdc_button u_up (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.raw            (data_s1.raw_up_button),
		.other_raw      (data_s1.raw_down_button),
		.clr_pend       (up_clr),
		.debounce_reads (cfg_q.debounce_reads),
		.repeat_reads   (cfg_q.repeat_reads),
		.stat           (up_stat)
	);

	tbdc_button u_down (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.raw            (data_s1.raw_down_button),
		.other_raw      (data_s1.raw_up_button),
		.clr_pend       (down_clr),
		.debounce_reads (cfg_q.debounce_reads),
		.repeat_reads   (cfg_q.repeat_reads),
		.stat           (down_stat)
	);

	// A release with the other button held reverses the sign and swallows both
	// requests; otherwise up wins over down and down stays pending.
	always_comb begin
		dbl_any     = up_stat.dbl | down_stat.dbl;
		cmd.negate  = dbl_any;
		cmd.up_go   = !dbl_any && up_stat.level && up_stat.pend;
		cmd.down_go = !dbl_any && !cmd.up_go && down_stat.level && down_stat.pend;
		up_clr      = dbl_any | cmd.up_go;
		down_clr    = dbl_any | cmd.down_go;
	end

	tbdc_duty u_duty (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd),
		.step   (cfg_q.duty_step),
		.stat   (duty_stat)
	);

	// Lamps: count down, reload on a processed press.
	always_comb begin
		up_lamp_n   = (up_lamp_q != '0) ? up_lamp_q - 16'd1 : up_lamp_q;
		down_lamp_n = (down_lamp_q != '0) ? down_lamp_q - 16'd1 : down_lamp_q;
		if (cmd.up_go) begin
			up_lamp_n = cfg_q.lamp_hold_ticks;
		end
		if (cmd.down_go) begin
			down_lamp_n = cfg_q.lamp_hold_ticks;
		end
	end

	// Display strobe: decrement with wrap, pulse and reload on reaching zero.
	always_comb begin
		disp_dec = disp_q - 16'd1;
		strobe   = (disp_dec == '0);
		disp_n   = strobe ? cfg_q.display_ticks : disp_dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_lamp_q   <= '0;
			down_lamp_q <= '0;
			disp_q      <= tbdc_pkg::RST_DISPLAY_TICKS;
		end else if (advance) begin
			up_lamp_q   <= up_lamp_n;
			down_lamp_q <= down_lamp_n;
			disp_q      <= disp_n;
		end
	end

	// Result register: load on advance, drop the valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.up_level       <= up_stat.level;
			out_q.down_level     <= down_stat.level;
			out_q.duty_magnitude <= duty_stat.mag;
			out_q.reverse_dir    <= duty_stat.neg;
			out_q.drive_update   <= cmd.negate | cmd.up_go | cmd.down_go;
			out_q.up_ack_lamp    <= (up_lamp_n != '0);
			out_q.down_ack_lamp  <= (down_lamp_n != '0);
			out_q.at_plus_full   <= duty_stat.plus_full;
			out_q.at_minus_full  <= duty_stat.minus_full;
			out_q.display_strobe <= strobe;
		end
	end

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advance did not load a result");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1)))
		else $error("input stage lost a stalled transaction");

	a_full_scales_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.at_plus_full && out_q.at_minus_full))
		else $error("both full-scale lamps lit");

	a_plus_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.at_plus_full) |->
			(!out_q.reverse_dir &&
			 out_q.duty_magnitude == tbdc_pkg::MAG_W'(tbdc_pkg::DUTY_FULL_SCALE)))
		else $error("plus full-scale lamp with wrong duty");

	a_single_press: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !(cmd.up_go && cmd.down_go) && !(cmd.negate && (cmd.up_go || cmd.down_go)))
		else $error("more than one duty action in a tick");

endmodule
`default_nettype wire
